// ----- src/apf_pkg.sv -----
// ----------------------------------------------------------------------------
// apf_pkg
// Shared types and constants for the articulation point finder.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int unsigned VtxW     = 6;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned MaxNodes = 64;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic            opcode;
    logic [VtxW-1:0] end_a;
    logic [VtxW-1:0] end_b;
  } in_item_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            found;
    logic            last;
    logic            overflow;
  } out_item_t;

  // controller -> datapath commands
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_ADD,
    CMD_INIT,
    CMD_ROOT,
    CMD_EDGE,
    CMD_BACK,
    CMD_POP,
    CMD_RESTORE,
    CMD_PARENT,
    CMD_EMIT,
    CMD_DONE
  } cmd_e;

  typedef struct packed {
    logic root_free;    // current root vertex is unvisited
    logic root_end;     // root scan past last vertex
    logic stack_empty;
    logic top_root;     // only the root frame is on the stack
    logic cur_more;     // top cursor below edge total
    logic edge_back;    // fetched edge leads to a visited vertex
    logic emit_end;     // emit scan past last vertex
    logic emit_hit;     // current emit vertex is marked
  } apf_status_t;

endpackage

// ----- src/apf_ram.sv -----
// ----------------------------------------------------------------------------
// apf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module apf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/apf_datapath.sv -----
// ----------------------------------------------------------------------------
// apf_datapath
// Edge store, walk stack, vertex tables and result formatting.
// ----------------------------------------------------------------------------
module apf_datapath
  import apf_pkg::*;
#(
  parameter int unsigned MaxEdges = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_e        cmd_i,
  input  in_item_t    in_i,
  input  logic [CfgW-1:0] node_count_i,
  output apf_status_t status_o,
  output out_item_t   out_o
);

  localparam int unsigned NW = $clog2(MaxNodes);
  localparam int unsigned EW = $clog2(MaxEdges);
  localparam int unsigned TW = $clog2(MaxEdges + 1);
  localparam int unsigned CW = $clog2(MaxNodes + 1);
  localparam int unsigned FW = 3 * NW + TW;

  logic [TW-1:0] etot_q;
  logic          drop_q;
  logic [CW-1:0] n_lim;
  logic [MaxNodes-1:0] vis_q, cut_q;
  logic [CW-1:0] sp_q;
  logic [NW-1:0] tv_q, tl_q, td_q, pv_q, cl_q;
  logic [TW-1:0] tc_q;
  logic [NW-1:0] clk_cnt_q;
  logic [CW-1:0] rootc_q;
  logic [CW-1:0] root_q;
  logic [CW-1:0] emv_q;

  logic [2*VtxW-1:0] edge_rd;
  logic [VtxW-1:0] ea, eb;
  logic [NW-1:0] nb, disc_rd, disc_waddr;
  logic          has_par, ok, adj, push, root_new, disc_we;
  logic [FW-1:0] stk_wdata, stk_rd;
  logic [NW-1:0] fr_v, fr_l, fr_d;
  logic [TW-1:0] fr_c;
  logic          more_after;

  always_comb begin
    n_lim = (node_count_i > CfgW'(MaxNodes)) ? CW'(MaxNodes) : CW'(node_count_i);
  end

  assign has_par = sp_q > CW'(1);
  assign ea = edge_rd[VtxW-1:0];
  assign eb = edge_rd[2*VtxW-1:VtxW];
  assign {fr_v, fr_c, fr_l, fr_d} = stk_rd;
  assign stk_wdata = {tv_q, tc_q + TW'(1), tl_q, td_q};

  apf_ram #(.Width(2*VtxW), .Depth(MaxEdges)) u_edges (
    .clk_i   (clk_i),
    .we_i    (cmd_i == CMD_ADD && etot_q < TW'(MaxEdges)),
    .waddr_i (EW'(etot_q)),
    .wdata_i ({in_i.end_b, in_i.end_a}),
    .raddr_i (EW'(tc_q)),
    .rdata_o (edge_rd)
  );

  apf_ram #(.Width(NW), .Depth(MaxNodes)) u_disc (
    .clk_i   (clk_i),
    .we_i    (disc_we),
    .waddr_i (disc_waddr),
    .wdata_i (clk_cnt_q),
    .raddr_i (nb),
    .rdata_o (disc_rd)
  );

  apf_ram #(.Width(FW), .Depth(MaxNodes)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (NW'(sp_q - CW'(1))),
    .wdata_i (stk_wdata),
    .raddr_i (NW'(sp_q - CW'(2))),
    .rdata_o (stk_rd)
  );

  always_comb begin
    ok  = ({{(CW){1'b0}}, ea} < {{(VtxW){1'b0}}, n_lim}) &&
          ({{(CW){1'b0}}, eb} < {{(VtxW){1'b0}}, n_lim});
    adj = 1'b1;
    nb  = NW'(eb);
    if (NW'(ea) == tv_q) nb = NW'(eb);
    else if (NW'(eb) == tv_q) nb = NW'(ea);
    else adj = 1'b0;
    if (!ok) adj = 1'b0;
    if (has_par && nb == pv_q) adj = 1'b0;
  end

  assign push       = cmd_i == CMD_EDGE && adj && !vis_q[nb] && sp_q < CW'(MaxNodes);
  assign root_new   = cmd_i == CMD_ROOT && !vis_q[NW'(root_q)];
  assign disc_we    = push || root_new;
  assign disc_waddr = push ? nb : NW'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etot_q <= '0; drop_q <= 1'b0; vis_q <= '0; cut_q <= '0;
      sp_q <= '0; clk_cnt_q <= '0; rootc_q <= '0; root_q <= '0;
      emv_q <= '0; tv_q <= '0; tc_q <= '0; tl_q <= '0; td_q <= '0;
      pv_q <= '0; cl_q <= '0;
    end else begin
      case (cmd_i)
        CMD_ADD: begin
          if (etot_q < TW'(MaxEdges)) etot_q <= etot_q + TW'(1);
          else drop_q <= 1'b1;
        end
        CMD_INIT: begin
          vis_q <= '0; cut_q <= '0; clk_cnt_q <= '0; root_q <= '0;
          sp_q <= '0; emv_q <= '0;
        end
        CMD_ROOT: begin
          if (root_new) begin
            vis_q[NW'(root_q)] <= 1'b1;
            clk_cnt_q <= clk_cnt_q + NW'(1);
            tv_q <= NW'(root_q);
            tc_q <= '0;
            tl_q <= clk_cnt_q;
            td_q <= clk_cnt_q;
            sp_q <= CW'(1);
            rootc_q <= '0;
          end
          root_q <= root_q + CW'(1);
        end
        CMD_EDGE: begin
          if (push) begin
            vis_q[nb] <= 1'b1;
            clk_cnt_q <= clk_cnt_q + NW'(1);
            tv_q <= nb;
            tc_q <= '0;
            tl_q <= clk_cnt_q;
            td_q <= clk_cnt_q;
            pv_q <= tv_q;
            sp_q <= sp_q + CW'(1);
          end else begin
            tc_q <= tc_q + TW'(1);
          end
        end
        CMD_BACK: begin
          if (disc_rd < tl_q) tl_q <= disc_rd;
        end
        CMD_POP: begin
          sp_q <= sp_q - CW'(1);
          if (has_par) begin
            cl_q <= tl_q;
          end else if (rootc_q > CW'(1)) begin
            cut_q[tv_q] <= 1'b1;
          end
        end
        CMD_RESTORE: begin
          tv_q <= fr_v;
          tc_q <= fr_c;
          td_q <= fr_d;
          tl_q <= (cl_q < fr_l) ? cl_q : fr_l;
          if (has_par) begin
            if (cl_q >= fr_d) cut_q[fr_v] <= 1'b1;
          end else begin
            rootc_q <= rootc_q + CW'(1);
          end
        end
        CMD_PARENT: begin
          pv_q <= fr_v;
        end
        CMD_EMIT: begin
          emv_q <= emv_q + CW'(1);
        end
        CMD_DONE: begin
          etot_q <= '0; drop_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // flag whether any marked vertex lies after emv_q, for last-flag lookahead
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < MaxNodes; i++) begin
      if (CW'(i) > emv_q && CW'(i) < n_lim && cut_q[i]) more_after = 1'b1;
    end
  end

  assign status_o.root_free   = root_q < n_lim && !vis_q[NW'(root_q)];
  assign status_o.root_end    = root_q >= n_lim;
  assign status_o.stack_empty = sp_q == '0;
  assign status_o.top_root    = sp_q == CW'(1);
  assign status_o.cur_more    = tc_q < etot_q;
  assign status_o.edge_back   = adj && vis_q[nb];
  assign status_o.emit_end    = emv_q >= n_lim;
  assign status_o.emit_hit    = emv_q < n_lim && cut_q[NW'(emv_q)];

  always_comb begin
    out_o.vertex   = VtxW'(emv_q);
    out_o.found    = status_o.emit_hit;
    out_o.last     = status_o.emit_hit ? !more_after : 1'b1;
    out_o.overflow = drop_q;
    if (!status_o.emit_hit) out_o.vertex = '0;
  end

endmodule

// ----- src/apf_ctrl.sv -----
// ----------------------------------------------------------------------------
// apf_ctrl
// Sequencer for edge loading, the depth-first walk and result emission.
// ----------------------------------------------------------------------------
module apf_ctrl
  import apf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  apf_status_t status_i,
  input  logic        out_last_i,
  output cmd_e        cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ROOT    = 3'd1;
  localparam logic [2:0] S_WALK    = 3'd2;
  localparam logic [2:0] S_EDGE    = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_BACK    = 3'd5;
  localparam logic [2:0] S_RESTORE = 3'd6;
  localparam logic [2:0] S_PARENT  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o = CMD_NOP;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_ADD) begin
            cmd_o = CMD_ADD;
          end else begin
            cmd_o = CMD_INIT;
            state_d = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (status_i.root_end) begin
          state_d = S_EMIT;
        end else begin
          cmd_o = CMD_ROOT;
          if (status_i.root_free) state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (status_i.stack_empty) begin
          state_d = S_ROOT;
        end else if (status_i.cur_more) begin
          state_d = S_EDGE;
        end else begin
          cmd_o = CMD_POP;
          if (!status_i.top_root) state_d = S_RESTORE;
        end
      end
      S_EDGE: begin
        cmd_o = CMD_EDGE;
        state_d = status_i.edge_back ? S_BACK : S_WALK;
      end
      S_BACK: begin
        cmd_o = CMD_BACK;
        state_d = S_WALK;
      end
      S_RESTORE: begin
        cmd_o = CMD_RESTORE;
        state_d = S_PARENT;
      end
      S_PARENT: begin
        cmd_o = CMD_PARENT;
        state_d = S_WALK;
      end
      S_EMIT: begin
        if (status_i.emit_end) begin
          out_valid_o = 1'b1;
          if (!out_stall_i) begin
            cmd_o = CMD_DONE;
            state_d = S_IDLE;
          end
        end else if (status_i.emit_hit) begin
          out_valid_o = 1'b1;
          if (!out_stall_i) begin
            if (out_last_i) begin
              cmd_o = CMD_DONE;
              state_d = S_IDLE;
            end else begin
              cmd_o = CMD_EMIT;
            end
          end
        end else begin
          cmd_o = CMD_EMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/articulation_point_finder.sv -----
// ----------------------------------------------------------------------------
// articulation_point_finder
// Edge load: each transfer is accepted while the sequencer is idle. Run: a
// scan over the vertices for tree roots; per visited vertex, a walk step and
// an edge fetch per stored edge entry plus a back-edge step per edge to an
// already visited vertex; pop, restore and parent steps per pop, the pop alone
// for a tree root; then a scan over the vertices for results, held by output
// stalls. Input stalls for the whole run. Reset clears control state; memories need no clear.
module articulation_point_finder
  import apf_pkg::*;
#(
  parameter int unsigned MaxEdges = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);

  logic [CfgW-1:0] node_count_q;
  cmd_e            cmd;
  apf_status_t     status;

  assign pready = 1'b1;
  assign prdata = (paddr[1:1] == REG_NODE_COUNT) ? {25'd0, node_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CfgW'(64);
    end else if (psel && penable && pwrite && paddr[1:1] == REG_NODE_COUNT) begin
      node_count_q <= pwdata[CfgW-1:0];
    end
  end

  apf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .out_last_i  (out_data_o.last),
    .cmd_o       (cmd)
  );

  apf_datapath #(.MaxEdges(MaxEdges)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_i         (in_data_i),
    .node_count_i (node_count_q),
    .status_o     (status),
    .out_o        (out_data_o)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the articulation point finder. Edges and run
// commands are sent with random gaps. Each accepted command updates a local
// model of the edge store, and each run predicts the cut vertices in order.
// Each result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import apf_pkg::*;

  localparam int unsigned NODE_LIMIT = 64;
  localparam int unsigned EDGE_LIMIT = 256;
  localparam int unsigned STALL_LIMIT = 400000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       psel;
  logic       penable;
  logic       pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic       pready;

  articulation_point_finder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  logic [VtxW-1:0] edge_a_q[$];
  logic [VtxW-1:0] edge_b_q[$];
  bit              edges_dropped;
  logic [CfgW-1:0] node_count;
  out_item_t       cut_results_q[$];
  int unsigned     mismatches;
  int unsigned     quiet_cycles;
  bit              gaps_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Tarjan walk over the stored edges, results queued in vertex order
  function automatic void predict_cuts();
    int unsigned n;
    int unsigned clk_cnt;
    int unsigned kids;
    int unsigned sp;
    int unsigned top;
    int unsigned v;
    int unsigned nb;
    int unsigned p;
    int unsigned cnt;
    int unsigned a;
    int unsigned b;
    bit          seen[NODE_LIMIT];
    bit          cut[NODE_LIMIT];
    int unsigned disc[NODE_LIMIT];
    int unsigned lowl[NODE_LIMIT];
    int unsigned stk_v[NODE_LIMIT];
    int unsigned stk_c[NODE_LIMIT];
    out_item_t   res;
    n = (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
    for (int i = 0; i < NODE_LIMIT; i++) begin
      seen[i] = 0;
      cut[i] = 0;
    end
    clk_cnt = 0;
    for (int r = 0; r < n; r++) begin
      if (seen[r]) continue;
      seen[r] = 1;
      disc[r] = clk_cnt;
      lowl[r] = clk_cnt;
      clk_cnt++;
      kids = 0;
      stk_v[0] = r;
      stk_c[0] = 0;
      sp = 1;
      while (sp > 0) begin
        top = sp - 1;
        v = stk_v[top];
        if (stk_c[top] < edge_a_q.size()) begin
          a = edge_a_q[stk_c[top]];
          b = edge_b_q[stk_c[top]];
          stk_c[top]++;
          if (a >= n || b >= n) continue;
          if (a == v) nb = b;
          else if (b == v) nb = a;
          else continue;
          if (top > 0 && nb == stk_v[top-1]) continue;
          if (!seen[nb]) begin
            if (sp < NODE_LIMIT) begin
              seen[nb] = 1;
              disc[nb] = clk_cnt;
              lowl[nb] = clk_cnt;
              clk_cnt++;
              stk_v[sp] = nb;
              stk_c[sp] = 0;
              sp++;
            end
          end else if (disc[nb] < lowl[v]) begin
            lowl[v] = disc[nb];
          end
        end else begin
          sp--;
          if (sp > 0) begin
            p = stk_v[sp-1];
            if (lowl[v] < lowl[p]) lowl[p] = lowl[v];
            if (sp > 1) begin
              if (lowl[v] >= disc[p]) cut[p] = 1;
            end else begin
              kids++;
            end
          end else if (kids > 1) begin
            cut[r] = 1;
          end
        end
      end
    end
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (cut[i] && cnt < 64) begin
        res.vertex = VtxW'(i);
        res.found = 1'b1;
        res.last = 1'b0;
        res.overflow = edges_dropped;
        cut_results_q = {cut_results_q, res};
        cnt++;
      end
    end
    if (cnt == 0) begin
      res.vertex = '0;
      res.found = 1'b0;
      res.last = 1'b1;
      res.overflow = edges_dropped;
      cut_results_q = {cut_results_q, res};
    end else begin
      cut_results_q[cut_results_q.size()-1].last = 1'b1;
    end
    edge_a_q.delete();
    edge_b_q.delete();
    edges_dropped = 0;
  endfunction

  task automatic send_item(input logic op, input logic [VtxW-1:0] a,
                           input logic [VtxW-1:0] b);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.opcode = op;
    in_data.end_a = a;
    in_data.end_b = b;
    do @(posedge clk); while (in_stall);
    if (op == OP_RUN) begin
      predict_cuts();
    end else if (edge_a_q.size() < EDGE_LIMIT) begin
      edge_a_q = {edge_a_q, a};
      edge_b_q = {edge_b_q, b};
    end else begin
      edges_dropped = 1;
    end
  endtask

  task automatic add_edge(input int unsigned a, input int unsigned b);
    send_item(OP_ADD, a[VtxW-1:0], b[VtxW-1:0]);
  endtask

  task automatic run_search();
    send_item(OP_RUN, VtxW'($urandom), VtxW'($urandom));
    @(negedge clk);
    in_valid = 1'b0;
    wait (cut_results_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_node_count(input int unsigned value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {REG_NODE_COUNT, 1'b0};
    pwdata = {$urandom_range(1) ? 25'h1ffffff : 25'h0, value[CfgW-1:0]};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    node_count = value[CfgW-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_small_graphs();
    write_node_count(3);
    add_edge(0, 1);
    add_edge(1, 2);
    run_search();
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 0);
    run_search();
    run_search();
  endtask

  task automatic test_special_cases();
    write_node_count(1);
    add_edge(0, 0);
    run_search();
    write_node_count(0);
    add_edge(0, 1);
    run_search();
    write_node_count(127);
    add_edge(63, 62);
    add_edge(62, 61);
    add_edge(61, 61);
    add_edge(62, 61);
    add_edge(0, 63);
    run_search();
    write_node_count(64);
    add_edge(63, 0);
    add_edge(0, 1);
    add_edge(1, 2);
    run_search();
    write_node_count(5);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 40);
    add_edge(63, 3);
    run_search();
  endtask

  task automatic test_overflow();
    write_node_count(64);
    for (int i = 0; i < 260; i++) add_edge($urandom_range(63), $urandom_range(63));
    run_search();
    add_edge(5, 6);
    run_search();
  endtask

  task automatic test_random_graphs();
    int unsigned sent;
    int unsigned n;
    int unsigned k;
    sent = 0;
    while (sent < 110) begin
      gaps_on = (sent < 30 || sent > 80);
      if ($urandom_range(9) == 0) n = $urandom_range(64, 127);
      else n = $urandom_range(2, 16);
      write_node_count(n);
      if (n > 63) n = 64;
      k = $urandom_range(1, 2 * n);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(19) == 0) add_edge($urandom_range(63), $urandom_range(63));
        else add_edge($urandom_range(n - 1), $urandom_range(n - 1));
      end
      run_search();
      sent += k + 1;
    end
    gaps_on = 1;
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= gaps_on && ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cut_results_q.size() == 0) begin
        report_mismatch("unexpected transfer vertex", out_data.vertex, 0);
      end else begin
        want = cut_results_q.pop_front();
        if (out_data.vertex !== want.vertex)
          report_mismatch("vertex", out_data.vertex, want.vertex);
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    node_count = 7'd64;
    edges_dropped = 0;
    mismatches = 0;
    quiet_cycles = 0;
    gaps_on = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_small_graphs();
    test_special_cases();
    test_overflow();
    test_random_graphs();
    wait (cut_results_q.size() == 0);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && cut_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
